>>> hw/rtl/nfce_pkg.sv
// ----------------------------------------------------------------------------
// nfce_pkg
// Shared types and constants of the command frame encoder.
// ----------------------------------------------------------------------------
package nfce_pkg;

	localparam logic [7:0] PREAMBLE_BYTE   = 8'h00;
	localparam logic [7:0] START_CODE_BYTE = 8'hFF;
	localparam logic [7:0] POSTAMBLE_BYTE  = 8'h00;
	localparam logic [7:0] IDENT_RESET     = 8'hD4;
	localparam logic [7:0] COUNT_MIN       = 8'd1;
	localparam logic [7:0] COUNT_MAX       = 8'd254;
	localparam logic [7:0] COUNT_OVER      = 8'd255;

	// Default depth of the job queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	// One classified command byte with everything the back needs to frame it.
	typedef struct packed {
		logic       first;
		logic       last;
		logic [7:0] data;
		logic [7:0] len;
		logic [7:0] lcs;
		logic [7:0] ident;
		logic [7:0] dcs;
	} job_t;

endpackage

>>> hw/rtl/nfce_front.sv
// ----------------------------------------------------------------------------
// nfce_front
// Accepts command bytes, tracks the frame position and the running checksum,
// and hands one classified request per byte to the job queue.
// ----------------------------------------------------------------------------
module nfce_front import nfce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       queue_full,
	input  logic [7:0] data_byte,
	input  logic [7:0] byte_count,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	output logic       job_wr,
	output job_t       job
);

	logic       inside_frame_q;
	logic [7:0] bytes_left_q;
	logic [7:0] running_sum_q;
	logic [7:0] frame_identifier_q;

	logic [7:0] count;
	logic [7:0] len;
	logic [7:0] left_now;
	logic [7:0] left_next;
	logic [7:0] sum_base;
	logic [7:0] sum_next;
	logic       is_last;

	assign cfg_ready = 1'b1;
	assign job_wr    = push && !queue_full;

	always_comb begin
		count = byte_count;
		if (byte_count == 8'd0) begin
			count = COUNT_MIN;
		end else if (byte_count == COUNT_OVER) begin
			count = COUNT_MAX;
		end
	end

	assign len       = count + 8'd1;
	assign left_now  = inside_frame_q ? bytes_left_q : count;
	assign left_next = left_now - 8'd1;
	assign is_last   = (left_next == 8'd0);

	// The checksum of a new frame starts from the identifier current at its opening.
	assign sum_base  = inside_frame_q ? running_sum_q : frame_identifier_q;
	assign sum_next  = sum_base + data_byte;

	always_comb begin
		job.first = !inside_frame_q;
		job.last  = is_last;
		job.data  = data_byte;
		job.len   = len;
		job.lcs   = 8'd0 - len;
		job.ident = frame_identifier_q;
		job.dcs   = 8'd0 - sum_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_frame_q     <= 1'b0;
			bytes_left_q       <= 8'd0;
			running_sum_q      <= 8'd0;
			frame_identifier_q <= IDENT_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				frame_identifier_q <= cfg_data;
			end
			if (job_wr) begin
				inside_frame_q <= !is_last;
				bytes_left_q   <= left_next;
				running_sum_q  <= sum_next;
			end
		end
	end

endmodule

>>> hw/rtl/nfce_queue.sv
// ----------------------------------------------------------------------------
// nfce_queue
// Small first-in first-out queue of classified requests between the front
// and the back.
// ----------------------------------------------------------------------------
module nfce_queue import nfce_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wr_job,
	input  logic rd,
	output job_t rd_job,
	output logic full,
	output logic empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign full   = (count_q == CntW'(Depth));
	assign empty  = (count_q == '0);
	assign do_wr  = wr && !full;
	assign do_rd  = rd && !empty;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/nfce_back.sv
// ----------------------------------------------------------------------------
// nfce_back
// Expands each queued request into its output bytes, one per cycle while not
// stalled, and holds the oldest byte in an output register until it is popped.
// ----------------------------------------------------------------------------
module nfce_back import nfce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  logic       queue_empty,
	output logic       job_rd,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       end_of_frame
);

	localparam logic [3:0] PH_PRE0  = 4'd0;
	localparam logic [3:0] PH_PRE1  = 4'd1;
	localparam logic [3:0] PH_START = 4'd2;
	localparam logic [3:0] PH_LEN   = 4'd3;
	localparam logic [3:0] PH_LCS   = 4'd4;
	localparam logic [3:0] PH_IDENT = 4'd5;
	localparam logic [3:0] PH_DATA  = 4'd6;
	localparam logic [3:0] PH_DCS   = 4'd7;
	localparam logic [3:0] PH_POST  = 4'd8;

	logic [3:0] phase_q;
	logic       busy_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       eof_q;

	logic [3:0] phase;
	logic       advance;
	logic       emit;
	logic       done;
	logic [7:0] next_byte;
	logic       next_eof;

	// A request not yet started begins at the header or straight at its data byte.
	assign phase   = busy_q ? phase_q : (head.first ? PH_PRE0 : PH_DATA);
	assign advance = !out_valid_q || pop;
	assign emit    = advance && !queue_empty;
	assign done    = (phase == PH_POST) || ((phase == PH_DATA) && !head.last);
	assign job_rd  = emit && done;

	always_comb begin
		next_eof = 1'b0;
		case (phase)
			PH_PRE0:  next_byte = PREAMBLE_BYTE;
			PH_PRE1:  next_byte = PREAMBLE_BYTE;
			PH_START: next_byte = START_CODE_BYTE;
			PH_LEN:   next_byte = head.len;
			PH_LCS:   next_byte = head.lcs;
			PH_IDENT: next_byte = head.ident;
			PH_DATA:  next_byte = head.data;
			PH_DCS:   next_byte = head.dcs;
			PH_POST: begin
				next_byte = POSTAMBLE_BYTE;
				next_eof  = 1'b1;
			end
			default:  next_byte = POSTAMBLE_BYTE;
		endcase
	end

	assign empty        = !out_valid_q;
	assign out_byte     = out_byte_q;
	assign end_of_frame = eof_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= next_byte;
			eof_q      <= next_eof;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PRE0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= !queue_empty;
			end
			if (emit) begin
				if (done) begin
					busy_q <= 1'b0;
				end else begin
					busy_q  <= 1'b1;
					phase_q <= phase + 4'd1;
				end
			end
		end
	end

endmodule

>>> hw/rtl/nfc_command_frame_encoder.sv
// ----------------------------------------------------------------------------
// nfc_command_frame_encoder
// Requests are registered in the job queue, results in the output register.
// One output byte per cycle while a request is queued and the output register
// is empty or popped. A middle command byte gives one output byte, the opening
// byte seven, the closing byte three, one that both opens and closes nine.
// Reset (arst_n, asynchronous): queues empty, no frame open, identifier 0xD4.
// ----------------------------------------------------------------------------
module nfc_command_frame_encoder import nfce_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic [7:0] byte_count,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       end_of_frame,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic job_wr;
	job_t wr_job;
	logic job_rd;
	job_t head;
	logic queue_full;
	logic queue_empty;

	assign full = queue_full;

	nfce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.queue_full (queue_full),
		.data_byte  (data_byte),
		.byte_count (byte_count),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.job_wr     (job_wr),
		.job        (wr_job)
	);

	nfce_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_wr),
		.wr_job (wr_job),
		.rd     (job_rd),
		.rd_job (head),
		.full   (queue_full),
		.empty  (queue_empty)
	);

	nfce_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.queue_empty  (queue_empty),
		.job_rd       (job_rd),
		.pop          (pop),
		.empty        (empty),
		.out_byte     (out_byte),
		.end_of_frame (end_of_frame)
	);

endmodule

>>> hw/rtl/nfce_checker.sv
// ----------------------------------------------------------------------------
// nfce_assertions
// Port-level checks on the command frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
module nfce_assertions (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       end_of_frame
);

	// The end of frame is only ever marked on the postamble byte.
	a_eof_is_postamble: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && end_of_frame) |-> (out_byte == 8'h00))
		else $error("end_of_frame on a non-zero byte");

	// A waiting result that is not popped stays as it is.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(end_of_frame)))
		else $error("waiting result changed without a pop");

	// After every accepted request, a result is waiting at the output.
	a_push_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |-> ##2 !empty)
		else $error("accepted request produced no result");

	// Two end-of-frame bytes are never popped back to back.
	a_eof_not_first: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && end_of_frame) |=> !(!empty && end_of_frame && pop))
		else $error("two end-of-frame bytes back to back");

endmodule

bind nfc_command_frame_encoder nfce_assertions u_nfce_assertions (
	.clk          (clk),
	.arst_n       (arst_n),
	.push         (push),
	.full         (full),
	.empty        (empty),
	.pop          (pop),
	.out_byte     (out_byte),
	.end_of_frame (end_of_frame)
);

>>> tb/sv/nfce_checker.sv
// ----------------------------------------------------------------------------
// nfce_checker
// Watches the byte, configuration and framed-output channels of the command
// frame encoder, predicts the framed byte stream and compares every popped
// byte with the oldest prediction.
// ----------------------------------------------------------------------------
module nfce_checker import nfce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] data_byte,
	input  logic [7:0] byte_count,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] out_byte,
	input  logic       end_of_frame,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [7:0] cfg_data,
	output int         errors,
	output int         pending,
	output int         bytes_checked
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] value;
		logic       eof;
	} framed_byte_t;

	framed_byte_t framed_stream[$];

	logic [7:0] ident_reg;
	logic [7:0] bytes_left;
	logic [7:0] data_sum;
	logic       frame_open;

	function automatic void add_framed(input logic [7:0] value, input logic eof);
		framed_byte_t fb;
		fb.value = value;
		fb.eof   = eof;
		framed_stream.push_back(fb);
	endfunction

	function automatic void frame_command_byte(input logic [7:0] d, input logic [7:0] c);
		logic [7:0] n;
		logic [7:0] len;
		if (!frame_open) begin
			n = c;
			if (n == 8'd0)
				n = COUNT_MIN;
			if (n == COUNT_OVER)
				n = COUNT_MAX;
			len = n + 8'd1;
			add_framed(PREAMBLE_BYTE, 1'b0);
			add_framed(PREAMBLE_BYTE, 1'b0);
			add_framed(START_CODE_BYTE, 1'b0);
			add_framed(len, 1'b0);
			add_framed(8'd0 - len, 1'b0);
			add_framed(ident_reg, 1'b0);
			data_sum   = ident_reg;
			bytes_left = n;
			frame_open = 1'b1;
		end
		add_framed(d, 1'b0);
		data_sum   = data_sum + d;
		bytes_left = bytes_left - 8'd1;
		if (bytes_left == 8'd0) begin
			add_framed(8'd0 - data_sum, 1'b0);
			add_framed(POSTAMBLE_BYTE, 1'b1);
			frame_open = 1'b0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		framed_byte_t fb;
		if (!arst_n) begin
			ident_reg     = IDENT_RESET;
			bytes_left    = 8'd0;
			data_sum      = 8'd0;
			frame_open    = 1'b0;
			framed_stream.delete();
			errors        = 0;
			pending       = 0;
			bytes_checked = 0;
		end else begin
			// The result side is checked first, so that a byte popped at the
			// same edge as a request is never matched against its own prediction.
			if (pop && !empty) begin
				if (framed_stream.size() == 0) begin
					$error("unexpected framed byte: out_byte %02h end_of_frame %0b",
						out_byte, end_of_frame);
					errors++;
				end else begin
					fb = framed_stream.pop_front();
					if (out_byte !== fb.value) begin
						$error("out_byte: expected %02h, got %02h", fb.value, out_byte);
						errors++;
					end
					if (end_of_frame !== fb.eof) begin
						$error("end_of_frame: expected %0b, got %0b", fb.eof, end_of_frame);
						errors++;
					end
					bytes_checked++;
				end
			end
			if (cfg_valid && cfg_ready)
				ident_reg = cfg_data;
			if (push && !full)
				frame_command_byte(data_byte, byte_count);
			pending = framed_stream.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives command bytes and identifier writes into the command frame encoder
// with random gaps on both sides, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module testbench import nfce_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_BYTES = 270;
	localparam int CYCLE_LIMIT  = 400000;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] data_byte;
	logic [7:0] byte_count;
	logic       empty;
	logic       pop;
	logic [7:0] out_byte;
	logic       end_of_frame;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;

	int errors;
	int pending;
	int bytes_checked;
	int cycle_count;
	int bytes_sent;
	int frames_sent;
	int ident_writes;
	bit in_steady;
	bit out_steady;

	nfc_command_frame_encoder DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.byte_count  (byte_count),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.end_of_frame(end_of_frame),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	nfce_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.byte_count   (byte_count),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.end_of_frame (end_of_frame),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending),
		.bytes_checked(bytes_checked)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Entered and left at a falling edge; push stays high when no gap is drawn.
	task automatic push_byte(input logic [7:0] d, input logic [7:0] c);
		int gap;
		gap = in_steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push       <= 1'b1;
		data_byte  <= d;
		byte_count <= c;
		do @(posedge clk); while (full);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Later bytes of a frame carry a random count, which the block must ignore.
	task automatic send_frame(input logic [7:0] c);
		int n;
		n = (c == 8'd0) ? 1 : (c == COUNT_OVER) ? int'(COUNT_MAX) : int'(c);
		push_byte(8'($urandom_range(0, 255)), c);
		for (int i = 1; i < n; i++)
			push_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		frames_sent++;
	endtask

	// The identifier is only changed once every framed byte has been drained.
	task automatic write_ident(input logic [7:0] v);
		push <= 1'b0;
		while (pending != 0) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		ident_writes++;
	endtask

	initial begin : result_drain
		int gap;
		pop = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = out_steady ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int wait_cycles;
		bytes_sent   = 0;
		frames_sent  = 0;
		ident_writes = 0;
		in_steady    = 1'b0;
		out_steady   = 1'b0;
		arst_n       = 1'b0;
		push         = 1'b0;
		data_byte    = 8'h00;
		byte_count   = 8'h00;
		cfg_valid    = 1'b0;
		cfg_data     = 8'h00;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed frames under the reset identifier: single-byte frames, a
		// count of zero, extreme data and a later byte with a large count.
		push_byte(8'h00, 8'd1);
		frames_sent++;
		push_byte(8'hFF, 8'd0);
		frames_sent++;
		push_byte(8'hFF, 8'd2);
		push_byte(8'h00, 8'hFF);
		frames_sent++;
		push_byte(8'h80, 8'd3);
		push_byte(8'h7F, 8'h00);
		push_byte(8'h01, 8'h55);
		frames_sent++;

		// Extreme identifiers, with no gaps on either side for the first.
		write_ident(8'h00);
		in_steady  = 1'b1;
		out_steady = 1'b1;
		push_byte(8'h00, 8'd1);
		frames_sent++;
		push_byte(8'hAA, 8'd2);
		push_byte(8'h55, 8'hAA);
		frames_sent++;
		in_steady  = 1'b0;
		out_steady = 1'b0;
		write_ident(8'hFF);
		push_byte(8'hFF, 8'd2);
		push_byte(8'hFF, 8'd1);
		frames_sent++;
		push_byte(8'h01, 8'd0);
		frames_sent++;

		// Random frames, mostly short, under a fresh identifier every so often.
		// The long frame at the end makes up the rest of the byte budget.
		write_ident(IDENT_RESET);
		while (bytes_sent < RANDOM_BYTES - int'(COUNT_MAX)) begin
			if ($urandom_range(0, 5) == 0)
				write_ident(8'($urandom_range(0, 255)));
			in_steady  = ($urandom_range(0, 4) == 0);
			out_steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) == 0)
				send_frame(8'd0);
			else
				send_frame(8'($urandom_range(1, 8)));
		end

		// One frame of maximum length from a saturated count.
		write_ident(8'($urandom_range(0, 255)));
		in_steady  = 1'b0;
		out_steady = 1'b0;
		send_frame(COUNT_OVER);
		push <= 1'b0;

		while (pending != 0) @(posedge clk);
		wait_cycles = 20;
		repeat (wait_cycles) @(posedge clk);

		$display("Sent %0d command bytes in %0d frames over %0d identifier writes;",
			bytes_sent, frames_sent, ident_writes);
		$display("%0d framed bytes were checked, including a maximum-length frame.",
			bytes_checked);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
